>>> hw/rtl/tsac_pkg.sv
// Package for the temperature sensor averaging and calibration block.
// Shared constants, controller state type and controller/datapath command and status structs.
// No dependencies.
`default_nettype none

package tsac_pkg;

  localparam int unsigned CODE_W = 12;  // sensor code and trim width
  localparam int unsigned TEMP_W = 16;  // result temperature width
  localparam int unsigned NUM_W  = 20;  // divider dividend width
  localparam int unsigned DEN_W  = 12;  // divider divisor width
  localparam int unsigned PROD_W = 21;  // signed (avg - cold) * 165
  localparam int unsigned TEMP_CALC_W = 22;

  localparam logic [CODE_W-1:0] DEFAULT_HOT  = 12'd3148;
  localparam logic [CODE_W-1:0] DEFAULT_COLD = 12'd503;
  localparam logic [7:0]        SPAN_DEGREES = 8'd165;
  localparam logic [5:0]        LOW_DEGREES  = 6'd40;

  // configuration register indexes
  localparam logic REG_OTP_HOT  = 1'b0;
  localparam logic REG_OTP_COLD = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_QUOT_START,
    ST_QUOT
  } tsac_state_e;

  typedef struct packed {
    logic acc;         // add the accepted sample to the sum
    logic trig;        // closing sample: capture the average, clear sum
    logic mul;         // form (avg - cold) * 165
    logic quot_start;  // start the calibration divide
    logic load_out;    // load the output register
  } tsac_cmd_t;

  typedef struct packed {
    logic count_full;  // block of samples complete, next sample closes it
    logic out_busy;    // output register still holds an untaken result
    logic div_done;    // divider quotient valid this cycle
    logic calib_err;   // hot trim not above cold trim
  } tsac_status_t;

endpackage : tsac_pkg

`default_nettype wire

>>> hw/rtl/tsac_div.sv
// Restoring serial divider, one quotient bit per cycle, unsigned operands.
// Depends on tsac_pkg for operand widths.
`default_nettype none

module tsac_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [tsac_pkg::NUM_W-1:0] num_i,
  input  logic [tsac_pkg::DEN_W-1:0] den_i,
  output logic                      done_o,
  output logic [tsac_pkg::NUM_W-1:0] quot_o
);
  import tsac_pkg::*;

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quot_q, quot_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [DEN_W:0]   rem_q, rem_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             done_q, done_d;
  logic [DEN_W:0]   rem_shift;
  logic [DEN_W+1:0] trial;

  assign rem_shift = {rem_q[DEN_W-1:0], quot_q[NUM_W-1]};
  assign trial     = {1'b0, rem_shift} - {2'b00, den_q};

  always_comb begin
    quot_d = quot_q;
    den_d  = den_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      quot_d = num_i;
      den_d  = den_i;
      rem_d  = '0;
      cnt_d  = CNT_W'(NUM_W);
    end else if (cnt_q != '0) begin
      // trial subtract; a clear top bit means no borrow
      if (!trial[DEN_W+1]) begin
        rem_d = trial[DEN_W:0];
      end else begin
        rem_d = rem_shift;
      end
      quot_d = {quot_q[NUM_W-2:0], ~trial[DEN_W+1]};
      cnt_d  = cnt_q - CNT_W'(1);
      done_d = (cnt_q == CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    den_q  <= den_d;
    rem_q  <= rem_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule : tsac_div

`default_nettype wire

>>> hw/rtl/tsac_dp.sv
// Datapath: trim registers, sample accumulator, calibration divider, scaling and output register.
// Depends on tsac_pkg and tsac_div.
`default_nettype none

module tsac_dp #(
  parameter int unsigned AVG_COUNT = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  tsac_pkg::tsac_cmd_t          cmd_i,
  output tsac_pkg::tsac_status_t       status_o,
  input  logic [tsac_pkg::CODE_W-1:0]  sample_i,
  input  logic                         cfg_we_i,
  input  logic                         cfg_index_i,
  input  logic [tsac_pkg::CODE_W-1:0]  cfg_data_i,
  output logic                         out_valid_o,
  input  logic                         out_take_i,
  output logic [tsac_pkg::TEMP_W-1:0]  temperature_o,
  output logic                         preliminary_o,
  output logic                         calib_error_o
);
  import tsac_pkg::*;

  localparam int unsigned SUM_W = CODE_W + $clog2(AVG_COUNT);
  localparam int unsigned CNT_W = $clog2(AVG_COUNT + 1);
  // sum / AVG_COUNT as a multiply by the rounded-up reciprocal; exact for any SUM_W-bit sum
  localparam int unsigned AVG_SH  = SUM_W + $clog2(AVG_COUNT);
  localparam int unsigned RCP_W   = SUM_W + 2;
  localparam int unsigned AVG_RCP = ((1 << AVG_SH) + AVG_COUNT - 1) / AVG_COUNT;

  logic [CODE_W-1:0] otp_hot_q, otp_cold_q;
  logic [SUM_W-1:0]  sum_q;
  logic [CNT_W-1:0]  count_q;
  logic [CODE_W-1:0] avg_q;
  logic signed [PROD_W-1:0] prod_q;
  logic              neg_q;
  logic              out_valid_q;
  logic signed [TEMP_W-1:0] temp_q;
  logic              prelim_q, err_q;

  logic              use_otp;
  logic [CODE_W-1:0] hot_sel, cold_sel;
  logic              err;
  logic [DEN_W-1:0]  span;
  logic [RCP_W-1:0]  avg_rcp;
  logic [SUM_W+RCP_W-1:0] avg_prod;
  logic signed [CODE_W:0] diff;
  logic [PROD_W-1:0] prod_abs;
  logic              div_start;
  logic [NUM_W-1:0]  div_num;
  logic [DEN_W-1:0]  div_den;
  logic              div_done;
  logic [NUM_W-1:0]  div_quot;
  logic signed [TEMP_CALC_W-1:0] quot_s, temp_full;
  logic signed [TEMP_W-1:0] temp_sat;

  // trims: OTP values only when both are programmed
  assign use_otp  = (otp_hot_q != '0) && (otp_cold_q != '0);
  assign hot_sel  = use_otp ? otp_hot_q  : DEFAULT_HOT;
  assign cold_sel = use_otp ? otp_cold_q : DEFAULT_COLD;
  assign err      = (hot_sel <= cold_sel);
  assign span     = hot_sel - cold_sel;

  assign avg_rcp  = RCP_W'(AVG_RCP);
  assign avg_prod = sum_q * avg_rcp;

  assign diff     = $signed({1'b0, avg_q}) - $signed({1'b0, cold_sel});
  assign prod_abs = prod_q[PROD_W-1] ? (PROD_W'(0) - prod_q) : prod_q;

  assign div_start = cmd_i.quot_start;
  assign div_num   = prod_abs[NUM_W-1:0];
  assign div_den   = span;

  tsac_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // truncating signed division: divide magnitudes, restore the sign
  always_comb begin
    quot_s    = neg_q ? -$signed({2'b00, div_quot}) : $signed({2'b00, div_quot});
    temp_full = quot_s - $signed(TEMP_CALC_W'(LOW_DEGREES));
    if (temp_full > $signed(TEMP_CALC_W'(32767))) begin
      temp_sat = 16'sh7FFF;
    end else if (temp_full < -$signed(TEMP_CALC_W'(32768))) begin
      temp_sat = 16'sh8000;
    end else begin
      temp_sat = temp_full[TEMP_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      otp_hot_q   <= '0;
      otp_cold_q  <= '0;
      sum_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_OTP_HOT:  otp_hot_q  <= cfg_data_i;
          REG_OTP_COLD: otp_cold_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.trig) begin
        sum_q   <= '0;
        count_q <= '0;
      end else if (cmd_i.acc) begin
        sum_q   <= sum_q + SUM_W'(sample_i);
        count_q <= count_q + CNT_W'(1);
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_take_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.trig) begin
      avg_q <= avg_prod[AVG_SH +: CODE_W];
    end
    if (cmd_i.mul) begin
      prod_q <= PROD_W'(diff) * $signed({1'b0, SPAN_DEGREES});
    end
    if (cmd_i.quot_start) begin
      neg_q <= prod_q[PROD_W-1];
    end
    if (cmd_i.load_out) begin
      temp_q   <= err ? '0 : temp_sat;
      prelim_q <= ~use_otp;
      err_q    <= err;
    end
  end

  assign status_o.count_full = (count_q == CNT_W'(AVG_COUNT));
  assign status_o.out_busy   = out_valid_q;
  assign status_o.div_done   = div_done;
  assign status_o.calib_err  = err;

  assign out_valid_o   = out_valid_q;
  assign temperature_o = temp_q;
  assign preliminary_o = prelim_q;
  assign calib_error_o = err_q;

endmodule : tsac_dp

`default_nettype wire

>>> hw/rtl/tsac_ctrl.sv
// Controller state machine: sequences accumulation, averaging, scaling, calibration divide
// and result load. Depends on tsac_pkg.
`default_nettype none

module tsac_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  tsac_pkg::tsac_status_t status_i,
  output tsac_pkg::tsac_cmd_t    cmd_o
);
  import tsac_pkg::*;

  tsac_state_e state_q, state_d;
  logic        in_xfer;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_xfer = in_valid_i && in_ready_o;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        // a closing sample waits until the previous result has gone
        in_ready_o = !(status_i.count_full && status_i.out_busy);
        if (in_xfer) begin
          if (status_i.count_full) begin
            cmd_o.trig = 1'b1;
            state_d    = ST_MUL;
          end else begin
            cmd_o.acc = 1'b1;
          end
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_QUOT_START;
      end
      ST_QUOT_START: begin
        if (status_i.calib_err) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end else begin
          cmd_o.quot_start = 1'b1;
          state_d          = ST_QUOT;
        end
      end
      ST_QUOT: begin
        if (status_i.div_done) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule : tsac_ctrl

`default_nettype wire

>>> hw/rtl/temp_sensor_avg_calibrate_top.sv
// Top level of the temperature sensor averaging and two-point calibration block.
// Depends on tsac_pkg, tsac_ctrl and tsac_dp (which holds tsac_div).
//
// Usage:
//   s_axis carries 12-bit sensor conversions. The first AVG_COUNT conversions of a
//   block are summed, one per cycle. The next one closes the block: it is dropped and
//   starts the calibration, which yields one result on m_axis (temperature in tdata,
//   preliminary and calib_error in tuser).
//   On the closing transfer the average is taken by a reciprocal multiply, the next
//   cycle scales it, then a 20-step serial divider divides by the trim span and the
//   result is loaded into the output register that drives m_axis. s_axis_tready is
//   low from the closing transfer until the result is loaded. With the trims in error
//   the divide is skipped and the result is loaded once the scaling is done.
//   The result waits in an output register; conversions of the next block keep being
//   taken while the receiver stalls, only the next closing conversion waits for it.
//   cfg writes (index 0 hot trim, 1 cold trim) are always taken and should only be
//   issued while the block is idle.
//   Reset (rst_ni low, asynchronous) clears the trims (defaults selected), the sum,
//   the count and any pending result.
`default_nettype none

module temp_sensor_avg_calibrate_top #(
  parameter int unsigned AVG_COUNT = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [11:0] sample
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] temperature
  output logic [1:0]  m_axis_tuser,   // [0] preliminary, [1] calib_error
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [11:0] cfg_data_i
);
  import tsac_pkg::*;

  tsac_cmd_t    cmd;
  tsac_status_t status;
  logic         preliminary, calib_error;

  assign cfg_ready_o = 1'b1;

  tsac_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tsac_dp #(
    .AVG_COUNT (AVG_COUNT)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .sample_i      (s_axis_tdata[CODE_W-1:0]),
    .cfg_we_i      (cfg_valid_i && cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .out_valid_o   (m_axis_tvalid),
    .out_take_i    (m_axis_tvalid && m_axis_tready),
    .temperature_o (m_axis_tdata),
    .preliminary_o (preliminary),
    .calib_error_o (calib_error)
  );

  assign m_axis_tuser = {calib_error, preliminary};

endmodule : temp_sensor_avg_calibrate_top

`default_nettype wire

>>> hw/rtl/tsac_checker.sv
// Port-level checks for temp_sensor_avg_calibrate_top, bound to the top level.
// Depends on temp_sensor_avg_calibrate_top's port list only.
`default_nettype none

module tsac_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // calibration error forces a zero temperature
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata == 16'h0000)
    else $error("calib_error with nonzero temperature");

  // default trims are ordered, so an error only comes from OTP trims
  a_err_otp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> !m_axis_tuser[0])
    else $error("calib_error together with preliminary");

  // a result never follows an input transfer in the next cycle
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tvalid && s_axis_tready))
    else $error("result appeared too soon after an input transfer");

endmodule : tsac_checker

bind temp_sensor_avg_calibrate_top tsac_checker u_tsac_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

>>> test/tsac_temp_checker.sv
`timescale 1ns / 100ps
// Checker for temp_sensor_avg_calibrate_top: watches the trim, conversion and result
// channels, predicts every calibrated temperature and compares it with the block's output.
// Depends on tsac_pkg for the trim register indexes.

module tsac_temp_checker #(
  parameter int unsigned AVG_N = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic        cfg_index_i,
  input  logic [11:0] cfg_data_i,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [15:0] s_tdata_i,   // [11:0] sample
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [15:0] m_tdata_i,   // [15:0] temperature
  input  logic [1:0]  m_tuser_i,   // [0] preliminary, [1] calib_error
  output int          pending_o,
  output int          results_o,
  output int          mismatches_o
);

  import tsac_pkg::*;

  localparam int HOT_FALLBACK  = 3148;
  localparam int COLD_FALLBACK = 503;
  localparam int SPAN_DEG      = 165;
  localparam int OFFSET_DEG    = 40;
  localparam int AVG_DIV       = AVG_N;

  typedef struct packed {
    logic signed [15:0] temp;
    logic               prelim;
    logic               err;
  } temp_result_t;

  logic [11:0]  hot_trim = '0;
  logic [11:0]  cold_trim = '0;
  int           conv_sum = 0;
  int           conv_count = 0;
  int           results = 0;
  int           mismatches = 0;
  temp_result_t pending_temps[$];

  // two-point calibration of one averaged block
  function automatic temp_result_t calibrate_block(int sum, logic [11:0] hot_r,
                                                   logic [11:0] cold_r);
    temp_result_t r;
    int hot, cold, avg, span, t;
    r = '0;
    if (hot_r != '0 && cold_r != '0) begin
      hot = hot_r;
      cold = cold_r;
    end else begin
      hot = HOT_FALLBACK;
      cold = COLD_FALLBACK;
      r.prelim = 1'b1;
    end
    avg = sum / AVG_DIV;
    span = hot - cold;
    if (span <= 0) begin
      r.err = 1'b1;
    end else begin
      // int division truncates toward zero, so codes below cold do not wrap
      t = (avg - cold) * SPAN_DEG / span - OFFSET_DEG;
      if (t > 32767) begin
        t = 32767;
      end else if (t < -32768) begin
        t = -32768;
      end
      r.temp = 16'(t);
    end
    return r;
  endfunction

  always @(posedge clk_i) begin
    temp_result_t want, got;
    if (!rst_ni) begin
      hot_trim = '0;
      cold_trim = '0;
      conv_sum = 0;
      conv_count = 0;
      pending_temps.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_OTP_HOT:  hot_trim = cfg_data_i;
          REG_OTP_COLD: cold_trim = cfg_data_i;
          default: ;
        endcase
      end
      if (s_tvalid_i && s_tready_i) begin
        if (conv_count < AVG_DIV) begin
          conv_sum += s_tdata_i[11:0];
          conv_count++;
        end else begin
          // closing conversion is dropped, it only triggers the result
          pending_temps.push_back(calibrate_block(conv_sum, hot_trim, cold_trim));
          conv_sum = 0;
          conv_count = 0;
        end
      end
      if (m_tvalid_i && m_tready_i) begin
        got.temp = m_tdata_i;
        got.prelim = m_tuser_i[0];
        got.err = m_tuser_i[1];
        results++;
        if (pending_temps.size() == 0) begin
          if (mismatches < 10) begin
            $display("[%0t] unexpected result: temp %0d prelim %0b err %0b", $realtime,
                     got.temp, got.prelim, got.err);
          end
          mismatches++;
        end else begin
          want = pending_temps.pop_front();
          if (got !== want) begin
            if (mismatches < 10) begin
              $display("[%0t] result %0d: temp %0d/%0d prelim %0b/%0b err %0b/%0b (exp/act)",
                       $realtime, results, want.temp, got.temp, want.prelim, got.prelim,
                       want.err, got.err);
            end
            mismatches++;
          end
        end
      end
    end
    pending_o <= pending_temps.size();
    results_o <= results;
    mismatches_o <= mismatches;
  end

endmodule

>>> test/temp_sensor_avg_calibrate_top_tb.sv
`timescale 1ns / 100ps
// Testbench top for temp_sensor_avg_calibrate_top: drives trims and sensor conversions,
// stalls the result side, and gives the verdict from the count kept by tsac_temp_checker.
// Depends on tsac_pkg, the block's RTL and tsac_temp_checker.

module temp_sensor_avg_calibrate_top_tb;

  import tsac_pkg::*;

  localparam int unsigned AVG_N = 8;
  localparam int BLOCK_LEN      = AVG_N + 1;
  localparam int N_CONV         = 650;
  localparam int SETTLE_CYCLES  = 64;    // extra wait once no result is outstanding
  localparam int RX_HOLD_CYCLES = 400;
  localparam int PRESSURE_PHASE = 4;

  typedef enum int {
    CONV_UNIFORM,
    CONV_NEAR,
    CONV_FLAT
  } conv_mode_e;

  typedef enum int {
    TRIM_DEFAULT,
    TRIM_HOT_ONLY,
    TRIM_COLD_ONLY,
    TRIM_NORMAL,
    TRIM_INVERTED,
    TRIM_EDGE
  } trim_kind_e;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;    // [11:0] sample
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;    // [15:0] temperature
  logic [1:0]  m_axis_tuser;    // [0] preliminary, [1] calib_error
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic        cfg_index_i;
  logic [11:0] cfg_data_i;

  int pending_cnt, results_cnt, mismatch_cnt;
  int conv_sent = 0;
  int trim_settings = 0;
  bit hold_req = 1'b0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  temp_sensor_avg_calibrate_top #(
    .AVG_COUNT(AVG_N)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  tsac_temp_checker #(
    .AVG_N(AVG_N)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_i  (s_axis_tready),
    .s_tdata_i   (s_axis_tdata),
    .m_tvalid_i  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_i   (m_axis_tdata),
    .m_tuser_i   (m_axis_tuser),
    .pending_o   (pending_cnt),
    .results_o   (results_cnt),
    .mismatches_o(mismatch_cnt)
  );

  // mostly short idle stretches, now and then a long one
  function automatic int idle_len();
    if ($urandom_range(0, 9) < 8) begin
      return int'($urandom_range(1, 3));
    end
    return int'($urandom_range(10, 40));
  endfunction

  function automatic logic [11:0] pick_conv(conv_mode_e mode, int base);
    int v;
    case (mode)
      CONV_UNIFORM: v = int'($urandom_range(0, 4095));
      CONV_NEAR:    v = base + int'($urandom_range(0, 64)) - 32;
      default:      v = base;
    endcase
    if (v < 0) begin
      v = 0;
    end else if (v > 4095) begin
      v = 4095;
    end
    return 12'(v);
  endfunction

  // first phases force the trim errors and a half-programmed OTP
  task automatic pick_trims(input int phase, output logic [11:0] hot, output logic [11:0] cold);
    trim_kind_e kind;
    int c;
    kind = trim_kind_e'($urandom_range(0, 5));
    if (phase == 0) begin
      kind = TRIM_INVERTED;
    end else if (phase == 2) begin
      kind = TRIM_HOT_ONLY;
    end
    case (kind)
      TRIM_DEFAULT: begin
        hot = '0;
        cold = '0;
      end
      TRIM_HOT_ONLY: begin
        hot = 12'($urandom_range(1, 4095));
        cold = '0;
      end
      TRIM_COLD_ONLY: begin
        hot = '0;
        cold = 12'($urandom_range(1, 4095));
      end
      TRIM_NORMAL: begin
        c = int'($urandom_range(1, 3000));
        cold = 12'(c);
        hot = 12'($urandom_range(c + 1, 4095));
      end
      TRIM_INVERTED: begin
        c = int'($urandom_range(1, 4095));
        cold = 12'(c);
        hot = 12'($urandom_range(1, c));
      end
      default: begin
        case ($urandom_range(0, 2))
          0: begin hot = 12'd4095; cold = 12'd1; end
          1: begin hot = 12'd2; cold = 12'd1; end
          default: begin hot = 12'd4095; cold = 12'd4094; end
        endcase
      end
    endcase
    if (phase == 1) begin
      hot = 12'd2048;
      cold = 12'd2048;
    end
  endtask

  task automatic send_conv(input logic [11:0] v, input bit burst);
    int gap;
    gap = (burst || $urandom_range(0, 1) == 0) ? 0 : idle_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata <= {4'b0000, v};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    conv_sent++;
  endtask

  task automatic send_level_block(input logic [11:0] first, input logic [11:0] level,
                                  input logic [11:0] closer);
    send_conv(first, 1'b0);
    repeat (AVG_N - 1) send_conv(level, 1'b0);
    send_conv(closer, 1'b0);
  endtask

  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_cnt != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_trims(input logic [11:0] hot, input logic [11:0] cold);
    cfg_index_i <= REG_OTP_HOT;
    cfg_data_i <= hot;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_index_i <= REG_OTP_COLD;
    cfg_data_i <= cold;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    trim_settings++;
  endtask

  // result side: random stalls, eager stretches, and one long hold-off on request
  initial begin : result_sink
    int idle_left;
    int stretch_left;
    bit eager;
    bit hold_seen;
    idle_left = 0;
    stretch_left = 0;
    eager = 1'b0;
    hold_seen = 1'b0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        idle_left = RX_HOLD_CYCLES;
      end
      if (stretch_left == 0) begin
        eager = ($urandom_range(0, 3) == 0);
        stretch_left = int'($urandom_range(50, 300));
      end
      stretch_left--;
      if (idle_left > 0) begin
        m_axis_tready <= 1'b0;
        idle_left--;
      end else if (!eager && $urandom_range(0, 9) < 3) begin
        m_axis_tready <= 1'b0;
        idle_left = idle_len() - 1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    #2000000;
    $display("timeout with %0d results outstanding", pending_cnt);
    $display("** temp_sensor_avg_calibrate_top: FAILED **");
    $finish;
  end

  initial begin : stimulus
    logic [11:0] hot, cold;
    conv_mode_e mode;
    int phase, n_blocks, base;
    bit burst;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_OTP_HOT;
    cfg_data_i = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset trims select the defaults; average truncates to 0, well below cold
    send_level_block(12'd5, 12'd0, 12'd4095);
    // span of one code: full-scale average saturates high
    wait_for_results();
    write_trims(12'd2, 12'd1);
    send_level_block(12'd4095, 12'd4095, 12'd0);
    // zero average against a cold trim at the top saturates low
    wait_for_results();
    write_trims(12'd4095, 12'd4094);
    send_level_block(12'd7, 12'd0, 12'd4095);

    phase = 0;
    while (conv_sent < N_CONV) begin
      pick_trims(phase, hot, cold);
      wait_for_results();
      write_trims(hot, cold);
      burst = ($urandom_range(0, 3) == 0);
      n_blocks = int'($urandom_range(2, 8));
      if (phase == PRESSURE_PHASE) begin
        // back-to-back blocks against a held-off receiver fill the output register
        burst = 1'b1;
        n_blocks = 3;
        hold_req <= ~hold_req;
      end
      repeat (n_blocks) begin
        mode = conv_mode_e'($urandom_range(0, 2));
        case ($urandom_range(0, 3))
          0: base = 0;
          1: base = 4095;
          default: base = int'($urandom_range(0, 4095));
        endcase
        repeat (BLOCK_LEN) send_conv(pick_conv(mode, base), burst);
      end
      phase++;
    end

    wait_for_results();
    $display("Covered %0d conversions under %0d trim settings; %0d temperatures checked,",
             conv_sent, trim_settings, results_cnt);
    $display("incl. default and OTP trims, trim errors, saturation and a %0d-cycle hold-off.",
             RX_HOLD_CYCLES);
    if (mismatch_cnt == 0 && pending_cnt == 0) begin
      $display("** temp_sensor_avg_calibrate_top: PASSED **");
    end else begin
      $display("** temp_sensor_avg_calibrate_top: FAILED **");
    end
    $finish;
  end

endmodule
